### rtl/core/ellipse_inlier_scorer_unit_macros.svh
// Assertion macros for the ellipse inlier scorer.
`ifndef ELLIPSE_INLIER_SCORER_UNIT_MACROS_SVH
`define ELLIPSE_INLIER_SCORER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define EIS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EIS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define EIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/eis_pkg.sv
package eis_pkg;

    localparam int PT_W         = 20;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int RES_W        = 24;
    localparam int CNT_W        = 16;
    localparam int SUM_W        = 40;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 48;
    localparam int SQRT_STEPS   = 32;
    localparam int ITER_W       = 6;

    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_TILT      = 3'd2,
        REG_MAJOR     = 3'd3,
        REG_MINOR     = 3'd4,
        REG_THRESHOLD = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CORDIC,
        OP_M_XC,
        OP_M_YS,
        OP_M_YC,
        OP_M_XS,
        OP_YR,
        OP_M_VA,
        OP_DIV_INIT,
        OP_DIV,
        OP_M_UU,
        OP_M_VV,
        OP_SQ_INIT,
        OP_SQRT,
        OP_FIN
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_M_XC,
        ST_M_YS,
        ST_M_YC,
        ST_M_XS,
        ST_YR,
        ST_M_VA,
        ST_DIV_INIT,
        ST_DIV,
        ST_M_UU,
        ST_M_VV,
        ST_SQ_INIT,
        ST_SQRT,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [ITER_W-1:0] iter;
    } eis_cmd_t;

    function automatic logic [19:0] atan_lut(input logic [3:0] idx);
        logic [19:0] val;
        unique case (idx)
            4'd0:    val = 20'd737280;
            4'd1:    val = 20'd435242;
            4'd2:    val = 20'd229970;
            4'd3:    val = 20'd116736;
            4'd4:    val = 20'd58595;
            4'd5:    val = 20'd29326;
            4'd6:    val = 20'd14667;
            4'd7:    val = 20'd7334;
            4'd8:    val = 20'd3667;
            4'd9:    val = 20'd1833;
            4'd10:   val = 20'd917;
            4'd11:   val = 20'd458;
            4'd12:   val = 20'd229;
            4'd13:   val = 20'd115;
            4'd14:   val = 20'd57;
            default: val = 20'd29;
        endcase
        return val;
    endfunction

endpackage

### rtl/core/eis_ctrl.sv
module eis_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output eis_pkg::eis_cmd_t cmd
);
    import eis_pkg::*;

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_CORDIC;
            ST_CORDIC: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_M_XC;
                    cnt_next   = '0;
                end
            end
            ST_M_XC:     state_next = ST_M_YS;
            ST_M_YS:     state_next = ST_M_YC;
            ST_M_YC:     state_next = ST_M_XS;
            ST_M_XS:     state_next = ST_YR;
            ST_YR:       state_next = ST_M_VA;
            ST_M_VA:     state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(DIV_STEPS - 1)) begin
                    state_next = ST_M_UU;
                    cnt_next   = '0;
                end
            end
            ST_M_UU:     state_next = ST_M_VV;
            ST_M_VV:     state_next = ST_SQ_INIT;
            ST_SQ_INIT:  state_next = ST_SQRT;
            ST_SQRT: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_FIN;
                    cnt_next   = '0;
                end
            end
            ST_FIN:      state_next = ST_OUT;
            ST_OUT:      if (m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        m_valid  = (state_reg == ST_OUT);
        cmd.iter = cnt_reg;
        unique case (state_reg)
            ST_IDLE:     cmd.op = s_valid ? OP_LOAD : OP_NONE;
            ST_CORDIC:   cmd.op = OP_CORDIC;
            ST_M_XC:     cmd.op = OP_M_XC;
            ST_M_YS:     cmd.op = OP_M_YS;
            ST_M_YC:     cmd.op = OP_M_YC;
            ST_M_XS:     cmd.op = OP_M_XS;
            ST_YR:       cmd.op = OP_YR;
            ST_M_VA:     cmd.op = OP_M_VA;
            ST_DIV_INIT: cmd.op = OP_DIV_INIT;
            ST_DIV:      cmd.op = OP_DIV;
            ST_M_UU:     cmd.op = OP_M_UU;
            ST_M_VV:     cmd.op = OP_M_VV;
            ST_SQ_INIT:  cmd.op = OP_SQ_INIT;
            ST_SQRT:     cmd.op = OP_SQRT;
            ST_FIN:      cmd.op = OP_FIN;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

### rtl/core/eis_datapath.sv
module eis_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  eis_pkg::eis_cmd_t                     cmd,
    input  logic                                  cfg_wr_en,
    input  logic [eis_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [eis_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [eis_pkg::PT_W-1:0]       s_point_x,
    input  logic signed [eis_pkg::PT_W-1:0]       s_point_y,
    input  logic                                  s_restart,
    output logic [eis_pkg::RES_W-1:0]             m_residual,
    output logic                                  m_is_inlier,
    output logic [eis_pkg::CNT_W-1:0]             m_inlier_count,
    output logic [eis_pkg::SUM_W-1:0]             m_error_sum
);
    import eis_pkg::*;

    logic signed [19:0] center_x_reg, center_y_reg;
    logic [13:0]        tilt_reg;
    logic [18:0]        major_reg, minor_reg, thr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    logic               restart_reg;
    logic signed [20:0] dx_reg, dy_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [23:0] z_reg;
    logic signed [65:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [29:0]        u_reg, ya_reg;
    logic [47:0]        num_reg;
    logic [18:0]        rem_reg;
    logic [63:0]        sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [RES_W-1:0]   residual_reg;
    logic               inl_reg;

    logic [18:0]        a_eff, b_eff;
    logic signed [14:0] t_ext, t_adj;
    logic signed [23:0] z_init, atan_ext;
    logic signed [32:0] xs, ys;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [63:0] rot_sel, rot_q, rot_abs;
    logic [19:0]        rem_sh;
    logic               div_ge;
    logic [63:0]        sq_trial;
    logic               sq_take;
    logic               v_sat;
    logic [24:0]        big;
    logic [31:0]        root, dev;
    logic [32:0]        rnd;
    logic [RES_W-1:0]   res_v;
    logic               inl_v;
    logic [CNT_W-1:0]   cnt_base;
    logic [SUM_W-1:0]   sum_base;
    logic [SUM_W:0]     sum_add;

    assign a_eff = (major_reg == '0) ? 19'd1 : major_reg;
    assign b_eff = (minor_reg == '0) ? 19'd1 : minor_reg;

    assign t_ext  = $signed({1'b0, tilt_reg});
    assign t_adj  = (tilt_reg > 14'd5760) ? (t_ext - 15'sd11520) : t_ext;
    assign z_init = $signed({t_adj[14], t_adj, 8'd0});

    assign xs       = cy_reg >>> cmd.iter[3:0];
    assign ys       = cx_reg >>> cmd.iter[3:0];
    assign atan_ext = $signed({4'd0, atan_lut(cmd.iter[3:0])});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_M_XC: begin
                mul_a = $signed({{12{dx_reg[20]}}, dx_reg});
                mul_b = cx_reg;
            end
            OP_M_YS: begin
                mul_a = $signed({{12{dy_reg[20]}}, dy_reg});
                mul_b = cy_reg;
            end
            OP_M_YC: begin
                mul_a = $signed({{12{dy_reg[20]}}, dy_reg});
                mul_b = cx_reg;
            end
            OP_M_XS: begin
                mul_a = $signed({{12{dx_reg[20]}}, dx_reg});
                mul_b = cy_reg;
            end
            OP_M_VA: begin
                mul_a = $signed({3'd0, ya_reg});
                mul_b = $signed({14'd0, a_eff});
            end
            OP_M_UU: begin
                mul_a = $signed({3'd0, u_reg});
                mul_b = $signed({3'd0, u_reg});
            end
            OP_M_VV: begin
                mul_a = $signed({2'd0, num_reg[30:0]});
                mul_b = $signed({2'd0, num_reg[30:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign rot_sel = (cmd.op == OP_YR) ? (acc_reg - prod_reg[63:0] + 64'sh800000)
                                       : (acc_reg + prod_reg[63:0] + 64'sh800000);
    assign rot_q   = rot_sel >>> 24;
    assign rot_abs = rot_q[63] ? -rot_q : rot_q;

    assign rem_sh = {rem_reg, num_reg[47]};
    assign div_ge = rem_sh >= {1'b0, b_eff};

    assign sq_trial = sq_res_reg + sq_bit_reg;
    assign sq_take  = sq_n_reg >= sq_trial;

    assign v_sat = |num_reg[47:31];
    assign big   = {a_eff, 6'd0};
    assign root  = sq_res_reg[31:0];
    assign dev   = (root >= {7'd0, big}) ? (root - {7'd0, big}) : ({7'd0, big} - root);
    assign rnd   = ({1'b0, dev} + 33'd32) >> 6;
    assign res_v = (v_sat || (|rnd[32:24])) ? {RES_W{1'b1}} : rnd[23:0];
    assign inl_v = res_v <= {5'd0, thr_reg};

    assign cnt_base = restart_reg ? '0 : count_reg;
    assign sum_base = restart_reg ? '0 : sum_reg;
    assign sum_add  = {1'b0, sum_base} + {17'd0, res_v};

    always_comb begin
        count_next = cnt_base;
        sum_next   = sum_base;
        if (inl_v) begin
            if (cnt_base != {CNT_W{1'b1}}) count_next = cnt_base + 1'b1;
            sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            tilt_reg     <= '0;
            major_reg    <= 19'd16;
            minor_reg    <= 19'd16;
            thr_reg      <= 19'd32;
            count_reg    <= '0;
            sum_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_CENTER_X:  center_x_reg <= $signed(cfg_data);
                    REG_CENTER_Y:  center_y_reg <= $signed(cfg_data);
                    REG_TILT:      tilt_reg     <= cfg_data[13:0];
                    REG_MAJOR:     major_reg    <= cfg_data[18:0];
                    REG_MINOR:     minor_reg    <= cfg_data[18:0];
                    REG_THRESHOLD: thr_reg      <= cfg_data[18:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_FIN) begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        unique case (cmd.op)
            OP_LOAD: begin
                restart_reg <= s_restart;
                dx_reg <= $signed({s_point_x[19], s_point_x})
                        - $signed({center_x_reg[19], center_x_reg});
                dy_reg <= $signed({s_point_y[19], s_point_y})
                        - $signed({center_y_reg[19], center_y_reg});
                cx_reg <= 33'sd652032874;
                cy_reg <= '0;
                z_reg  <= z_init;
            end
            OP_CORDIC: begin
                if (!z_reg[23]) begin
                    cx_reg <= cx_reg - xs;
                    cy_reg <= cy_reg + ys;
                    z_reg  <= z_reg - atan_ext;
                end else begin
                    cx_reg <= cx_reg + xs;
                    cy_reg <= cy_reg - ys;
                    z_reg  <= z_reg + atan_ext;
                end
            end
            OP_M_YS:  acc_reg <= prod_reg[63:0];
            OP_M_YC:  u_reg   <= rot_abs[29:0];
            OP_M_XS:  acc_reg <= prod_reg[63:0];
            OP_YR:    ya_reg  <= rot_abs[29:0];
            OP_DIV_INIT: begin
                num_reg <= prod_reg[47:0] + {30'd0, b_eff[18:1]};
                rem_reg <= '0;
            end
            OP_DIV: begin
                rem_reg <= div_ge ? 19'(rem_sh - {1'b0, b_eff}) : rem_sh[18:0];
                num_reg <= {num_reg[46:0], div_ge};
            end
            OP_M_VV:  acc_reg <= prod_reg[63:0];
            OP_SQ_INIT: begin
                sq_n_reg   <= acc_reg + prod_reg[63:0];
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT: begin
                if (sq_take) begin
                    sq_n_reg   <= sq_n_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_FIN: begin
                residual_reg <= res_v;
                inl_reg      <= inl_v;
            end
            default: ;
        endcase
    end

    assign m_residual     = residual_reg;
    assign m_is_inlier    = inl_reg;
    assign m_inlier_count = count_reg;
    assign m_error_sum    = sum_reg;

endmodule

### rtl/core/ellipse_inlier_scorer_unit.sv
// A result is computed through 16 CORDIC steps, 48 restoring divide steps and 32 square-root
// steps, plus the multiply and control states.
// One point is in flight at a time; a new transaction is taken only once the last result is out.
// Reset: aresetn, synchronous, active low; the controller and the configuration registers
// return to their defaults and the inlier count and error sum clear.
`include "ellipse_inlier_scorer_unit_macros.svh"

module ellipse_inlier_scorer_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [eis_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [eis_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [eis_pkg::PT_W-1:0]       s_point_x,
    input  logic signed [eis_pkg::PT_W-1:0]       s_point_y,
    input  logic                                  s_restart,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [eis_pkg::RES_W-1:0]             m_residual,
    output logic                                  m_is_inlier,
    output logic [eis_pkg::CNT_W-1:0]             m_inlier_count,
    output logic [eis_pkg::SUM_W-1:0]             m_error_sum
);
    import eis_pkg::*;

    eis_cmd_t cmd;

    eis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    eis_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .s_restart      (s_restart),
        .m_residual     (m_residual),
        .m_is_inlier    (m_is_inlier),
        .m_inlier_count (m_inlier_count),
        .m_error_sum    (m_error_sum)
    );

    `EIS_ASSERT_IMPLY(a_ready_excl, aclk, aresetn, s_ready, !m_valid)
    `EIS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready && !m_valid)
    `EIS_ASSERT_IMPLY(a_inl_count, aclk, aresetn, m_valid && m_is_inlier, m_inlier_count != '0)
    `EIS_ASSERT_IMPLY(a_inl_sum, aclk, aresetn, m_valid && m_is_inlier,
        m_error_sum >= {16'd0, m_residual})

endmodule
